@@ rtl/pps_pkg.sv @@
package pps_pkg;

    localparam int DEFAULT_SET_CAPACITY = 256;
    localparam int KEY_WIDTH = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CHANNEL_MAX = 16'hFFFF;
    localparam logic [15:0] CHANNEL_ZERO = 16'h0000;

    localparam logic [4:0] DEPTH_1 = 5'd1;
    localparam logic [4:0] DEPTH_2 = 5'd2;
    localparam logic [4:0] DEPTH_4 = 5'd4;
    localparam logic [4:0] DEPTH_8 = 5'd8;
    localparam logic [4:0] DEPTH_16 = 5'd16;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic        has_color;
        logic [31:0] transparent_count;
        logic [31:0] semitransparent_count;
        logic [4:0]  needed_depth;
        logic [8:0]  distinct_colors;
        logic        set_overflow;
    } result_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 transparent;
        logic                 semitransparent;
        logic                 colored;
        logic [4:0]           depth;
        logic                 last_pixel;
    } entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

    typedef struct packed {
        logic pop;
        logic not_empty;
    } pop_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

    function automatic logic [4:0] channel_depth(input logic [15:0] v);
        logic [4:0] d;
        if (v == CHANNEL_ZERO || v == CHANNEL_MAX) begin
            d = DEPTH_1;
        end
        else if (v[15:8] != v[7:0]) begin
            d = DEPTH_16;
        end
        else if (v[15:4] != v[11:0]) begin
            d = DEPTH_8;
        end
        else if (v[15:2] != v[13:0]) begin
            d = DEPTH_4;
        end
        else if (v[15:1] != v[14:0]) begin
            d = DEPTH_2;
        end
        else begin
            d = DEPTH_1;
        end
        return d;
    endfunction

    function automatic logic [4:0] depth_max(input logic [4:0] a, input logic [4:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/pps_ram.sv @@
module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pps_front.sv @@
module pps_front (
    input  pps_pkg::pixel_t    pixel,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    output pps_pkg::push_ctl_t push_ctl_out,
    input  logic               queue_full,
    output pps_pkg::entry_t    entry
);

    logic       transparent;
    logic [4:0] depth_rg;
    logic [4:0] depth_all;

    always_comb
    begin
        transparent = (pixel.alpha == pps_pkg::CHANNEL_ZERO);
        depth_rg    = pps_pkg::depth_max(pps_pkg::channel_depth(pixel.red),
                                         pps_pkg::channel_depth(pixel.green));
        depth_all   = pps_pkg::depth_max(depth_rg, pps_pkg::channel_depth(pixel.blue));

        entry.transparent     = transparent;
        entry.semitransparent = !transparent && (pixel.alpha != pps_pkg::CHANNEL_MAX);
        entry.colored         = !transparent &&
                                ((pixel.red != pixel.green) || (pixel.green != pixel.blue));
        entry.depth           = transparent ? pps_pkg::DEPTH_1 : depth_all;
        entry.last_pixel      = pixel.last_pixel;
        entry.key             = transparent ? '0 :
                                {pixel.alpha, pixel.blue, pixel.green, pixel.red};
    end

    assign pixel_stall       = queue_full;
    assign push_ctl_out.push = pixel_valid && !queue_full;
    assign push_ctl_out.full = queue_full;

endmodule

@@ rtl/pps_queue.sv @@
module pps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::push_ctl_t push_ctl_in,
    input  pps_pkg::entry_t    entry_in,
    output logic               full,
    input  logic               pop,
    output pps_pkg::pop_ctl_t  pop_ctl_out,
    output pps_pkg::entry_t    entry_out
);

    localparam int PW = (pps_pkg::QUEUE_DEPTH > 1) ? $clog2(pps_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(pps_pkg::QUEUE_DEPTH + 1);

    pps_pkg::entry_t slot_reg [pps_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(pps_pkg::QUEUE_DEPTH));
    assign do_push  = push_ctl_in.push && !push_ctl_in.full;
    assign do_pop   = pop && (count_reg != '0);

    assign pop_ctl_out.pop       = do_pop;
    assign pop_ctl_out.not_empty = (count_reg != '0);
    assign entry_out             = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(pps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(pps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

@@ rtl/pps_back.sv @@
module pps_back #(
    parameter int SET_CAPACITY = pps_pkg::DEFAULT_SET_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::pop_ctl_t pop_ctl_in,
    input  pps_pkg::entry_t   entry,
    output logic              pop,
    output pps_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int TW = $clog2(SET_CAPACITY + 1);

    pps_pkg::back_state_t state_reg;
    pps_pkg::back_state_t state_next;

    pps_pkg::entry_t  cur_reg;
    pps_pkg::entry_t  cur_next;
    logic [TW-1:0]    idx_reg;
    logic [TW-1:0]    idx_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic             any_color_reg;
    logic             any_color_next;
    logic [31:0]      trans_reg;
    logic [31:0]      trans_next;
    logic [31:0]      semi_reg;
    logic [31:0]      semi_next;
    logic [4:0]       depth_reg;
    logic [4:0]       depth_next;
    logic [TW-1:0]    tally_reg;
    logic [TW-1:0]    tally_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    pps_pkg::result_t out_reg;
    pps_pkg::result_t out_next;

    logic                          rd_en;
    logic                          hit;
    logic                          miss_done;
    logic                          wr_en;
    logic                          out_free;
    logic                          load;
    logic                          has_room;
    logic [pps_pkg::KEY_WIDTH-1:0] rdata;

    pps_ram #(
        .WIDTH(pps_pkg::KEY_WIDTH),
        .DEPTH(SET_CAPACITY)
    ) u_color_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(tally_reg[AW-1:0]),
        .wdata(cur_reg.key),
        .re   (rd_en),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign has_room   = (tally_reg < TW'(SET_CAPACITY));
    assign out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        hit       = 1'b0;
        miss_done = 1'b0;
        wr_en     = 1'b0;
        load      = 1'b0;
        case (state_reg)
            pps_pkg::BK_IDLE:
            begin
                pop = pop_ctl_in.not_empty;
            end
            pps_pkg::BK_SCAN:
            begin
                rd_en     = (idx_reg < tally_reg);
                hit       = cmp_valid_reg && (rdata == cur_reg.key);
                miss_done = !hit && !rd_en && !cmp_valid_reg;
                wr_en     = miss_done && has_room;
            end
            pps_pkg::BK_FINISH:
            begin
                load = cur_reg.last_pixel && out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::BK_IDLE:
            begin
                if (pop_ctl_in.pop)
                begin
                    state_next = pps_pkg::BK_SCAN;
                end
            end
            pps_pkg::BK_SCAN:
            begin
                if (hit || miss_done)
                begin
                    state_next = pps_pkg::BK_FINISH;
                end
            end
            pps_pkg::BK_FINISH:
            begin
                if (!cur_reg.last_pixel || out_free)
                begin
                    state_next = pps_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cmp_valid_next = rd_en;
        any_color_next = any_color_reg;
        trans_next     = trans_reg;
        semi_next      = semi_reg;
        depth_next     = depth_reg;
        tally_next     = tally_reg;
        overflow_next  = overflow_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (pop_ctl_in.pop)
        begin
            cur_next = entry;
            idx_next = '0;
            if (entry.colored)
            begin
                any_color_next = 1'b1;
            end
            if (entry.transparent && trans_reg != pps_pkg::COUNT_MAX)
            begin
                trans_next = trans_reg + 32'd1;
            end
            if (entry.semitransparent && semi_reg != pps_pkg::COUNT_MAX)
            begin
                semi_next = semi_reg + 32'd1;
            end
            depth_next = pps_pkg::depth_max(depth_reg, entry.depth);
        end

        if (rd_en)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (miss_done)
        begin
            if (has_room)
            begin
                tally_next = tally_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        if (load)
        begin
            out_next.has_color             = any_color_reg;
            out_next.transparent_count     = trans_reg;
            out_next.semitransparent_count = semi_reg;
            out_next.needed_depth          = depth_reg;
            out_next.distinct_colors       = 9'(tally_reg);
            out_next.set_overflow          = overflow_reg;
            out_valid_next                 = 1'b1;
            any_color_next                 = 1'b0;
            trans_next                     = '0;
            semi_next                      = '0;
            depth_next                     = pps_pkg::DEPTH_1;
            tally_next                     = '0;
            overflow_next                  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pps_pkg::BK_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            any_color_reg <= 1'b0;
            trans_reg     <= '0;
            semi_reg      <= '0;
            depth_reg     <= pps_pkg::DEPTH_1;
            tally_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            any_color_reg <= any_color_next;
            trans_reg     <= trans_next;
            semi_reg      <= semi_next;
            depth_reg     <= depth_next;
            tally_reg     <= tally_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

@@ rtl/png_pixel_statistics_top.sv @@
// Pixel statistics for choosing a PNG color type and bit depth.
// Input channel: pixel / pixel_valid / pixel_stall carries one RGBA16 pixel
// per word; last_pixel marks the final pixel of an image.
// Output channel: result / result_valid / result_stall carries one summary
// word per image, produced after the pixel marked last, after which all
// statistics clear for the next image.
// The front classifies each pixel in the cycle it arrives and writes it into
// a two-word queue; pixel_stall rises only while that queue is full.
// The back takes one pixel at a time: it pops the pixel, then scans the
// color set through the single read port of the color RAM, one stored color
// per cycle, with registered read data; a miss is settled after the last
// read is compared, then a closing state finishes the pixel.
// The summary sits in an output register; while result_stall is high it holds
// and the back waits only if a further summary is ready to load.
// Reset clears all counters and flags; the color RAM needs no clearing since
// only entries below the color count are ever read.
module png_pixel_statistics_top #(
    parameter int SET_CAPACITY = pps_pkg::DEFAULT_SET_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pps_pkg::pixel_t  pixel,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    output pps_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);

    pps_pkg::push_ctl_t push_ctl;
    pps_pkg::pop_ctl_t  pop_ctl;
    pps_pkg::entry_t    front_entry;
    pps_pkg::entry_t    queue_entry;
    logic               queue_full;
    logic               back_pop;

    pps_front u_front (
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .push_ctl_out(push_ctl),
        .queue_full  (queue_full),
        .entry       (front_entry)
    );

    pps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_ctl_in(push_ctl),
        .entry_in   (front_entry),
        .full       (queue_full),
        .pop        (back_pop),
        .pop_ctl_out(pop_ctl),
        .entry_out  (queue_entry)
    );

    pps_back #(
        .SET_CAPACITY(SET_CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_ctl_in  (pop_ctl),
        .entry       (queue_entry),
        .pop         (back_pop),
        .result      (result),
        .result_valid(result_valid),
        .result_stall(result_stall)
    );

endmodule

@@ rtl/pps_checker.sv @@
module pps_checker #(
    parameter int SET_CAPACITY = pps_pkg::DEFAULT_SET_CAPACITY
) (
    input logic             clk,
    input logic             rst_n,
    input pps_pkg::result_t result,
    input logic             result_valid,
    input logic             result_stall
);

    localparam logic [8:0] CAP_SHOWN = 9'(SET_CAPACITY);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.needed_depth == pps_pkg::DEPTH_1 ||
                          result.needed_depth == pps_pkg::DEPTH_2 ||
                          result.needed_depth == pps_pkg::DEPTH_4 ||
                          result.needed_depth == pps_pkg::DEPTH_8 ||
                          result.needed_depth == pps_pkg::DEPTH_16))
        else $error("needed depth is not a legal bit depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.set_overflow |-> result.distinct_colors == CAP_SHOWN)
        else $error("overflow reported with color set not full");

endmodule

bind png_pixel_statistics_top pps_checker #(
    .SET_CAPACITY(SET_CAPACITY)
) u_pps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
);

@@ sim/png_pixel_statistics_top_test.sv @@
`timescale 1ns / 100ps

module png_pixel_statistics_top_test;

    localparam int SET_SIZE = pps_pkg::DEFAULT_SET_CAPACITY;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYCLES = 300;
    localparam int PIXEL_TARGET = 950;
    localparam int REPORT_LIMIT = 10;

    class image_stats_tracker;
        bit               any_color;
        bit [31:0]        transparent_tally;
        bit [31:0]        semitransparent_tally;
        bit [4:0]         depth_so_far;
        bit               known_colors[bit [63:0]];
        int unsigned      color_tally;
        bit               overflowed;
        pps_pkg::result_t expected_summaries[$];
        int               mismatches;
        int               summaries_checked;
        int               overflow_summaries;

        function new();
            mismatches = 0;
            summaries_checked = 0;
            overflow_summaries = 0;
            clear();
        endfunction

        function void clear();
            any_color = 1'b0;
            transparent_tally = '0;
            semitransparent_tally = '0;
            depth_so_far = pps_pkg::DEPTH_1;
            known_colors.delete();
            color_tally = 0;
            overflowed = 1'b0;
        endfunction

        function bit [4:0] depth_needed(bit [15:0] v);
            if (v == {16{v[15]}})
                return pps_pkg::DEPTH_1;
            if (v == {8{v[15:14]}})
                return pps_pkg::DEPTH_2;
            if (v == {4{v[15:12]}})
                return pps_pkg::DEPTH_4;
            if (v == {2{v[15:8]}})
                return pps_pkg::DEPTH_8;
            return pps_pkg::DEPTH_16;
        endfunction

        function void absorb_pixel(pps_pkg::pixel_t p);
            bit [15:0]        r;
            bit [15:0]        g;
            bit [15:0]        b;
            bit [4:0]         d;
            bit [63:0]        key;
            pps_pkg::result_t s;
            r = p.red;
            g = p.green;
            b = p.blue;
            if (p.alpha == pps_pkg::CHANNEL_ZERO)
            begin
                if (transparent_tally != pps_pkg::COUNT_MAX)
                    transparent_tally++;
                r = '0;
                g = '0;
                b = '0;
            end
            else
            begin
                if (r != g || g != b)
                    any_color = 1'b1;
                if (p.alpha != pps_pkg::CHANNEL_MAX &&
                    semitransparent_tally != pps_pkg::COUNT_MAX)
                    semitransparent_tally++;
                d = depth_needed(r);
                if (depth_needed(g) > d)
                    d = depth_needed(g);
                if (depth_needed(b) > d)
                    d = depth_needed(b);
                if (d > depth_so_far)
                    depth_so_far = d;
            end
            key = {p.alpha, b, g, r};
            if (!known_colors.exists(key))
            begin
                if (color_tally < SET_SIZE)
                begin
                    known_colors[key] = 1'b1;
                    color_tally++;
                end
                else
                begin
                    overflowed = 1'b1;
                end
            end
            if (p.last_pixel)
            begin
                s.has_color = any_color;
                s.transparent_count = transparent_tally;
                s.semitransparent_count = semitransparent_tally;
                s.needed_depth = depth_so_far;
                s.distinct_colors = color_tally[8:0];
                s.set_overflow = overflowed;
                expected_summaries.push_back(s);
                clear();
            end
        endfunction

        function string summary_text(pps_pkg::result_t s);
            return $sformatf("color=%0d trans=%0d semi=%0d depth=%0d colors=%0d ovf=%0d",
                             s.has_color, s.transparent_count, s.semitransparent_count,
                             s.needed_depth, s.distinct_colors, s.set_overflow);
        endfunction

        function void check_summary(pps_pkg::result_t got);
            pps_pkg::result_t want;
            bit               bad;
            if (expected_summaries.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: summary with no image pending: %s", summary_text(got));
                return;
            end
            want = expected_summaries.pop_front();
            summaries_checked++;
            if (want.set_overflow)
                overflow_summaries++;
            bad = (got.has_color !== want.has_color)
                || (got.transparent_count !== want.transparent_count)
                || (got.semitransparent_count !== want.semitransparent_count)
                || (got.needed_depth !== want.needed_depth)
                || (got.distinct_colors !== want.distinct_colors)
                || (got.set_overflow !== want.set_overflow);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("ERROR: summary %0d mismatch", summaries_checked);
                    $display("  expected %s", summary_text(want));
                    $display("  actual   %s", summary_text(got));
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    pps_pkg::pixel_t  pixel;
    logic             pixel_valid;
    logic             pixel_stall;
    pps_pkg::result_t result;
    logic             result_valid;
    logic             result_stall;

    image_stats_tracker stats = new();
    bit tx_idle_on;
    bit rx_idle_on;
    bit calm_tail;
    bit long_hold_req;
    int pixels_sent;
    int images_sent;

    png_pixel_statistics_top #(
        .SET_CAPACITY(SET_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pixel(pixel),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .result(result),
        .result_valid(result_valid),
        .result_stall(result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (rx_idle_on && !calm_tail && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
                stats.check_summary(result);
        end
    end

    function automatic pps_pkg::pixel_t make_pixel(logic [15:0] r, logic [15:0] g,
                                                   logic [15:0] b, logic [15:0] a);
        pps_pkg::pixel_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.alpha = a;
        p.last_pixel = 1'b0;
        return p;
    endfunction

    function automatic logic [15:0] random_channel();
        logic [15:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 6))
            0: return pps_pkg::CHANNEL_ZERO;
            1: return pps_pkg::CHANNEL_MAX;
            2: return {8{raw[1:0]}};
            3: return {4{raw[3:0]}};
            4: return {2{raw[7:0]}};
            default: return raw;
        endcase
    endfunction

    function automatic pps_pkg::pixel_t random_pixel();
        pps_pkg::pixel_t p;
        p.red = random_channel();
        if ($urandom_range(0, 2) == 0)
        begin
            p.green = p.red;
            p.blue = p.red;
        end
        else
        begin
            p.green = random_channel();
            p.blue = random_channel();
        end
        case ($urandom_range(0, 5))
            0: p.alpha = pps_pkg::CHANNEL_ZERO;
            1, 2: p.alpha = pps_pkg::CHANNEL_MAX;
            4: p.alpha = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFE;
            default: p.alpha = 16'($urandom);
        endcase
        p.last_pixel = 1'b0;
        return p;
    endfunction

    task automatic send_pixel(pps_pkg::pixel_t p);
        bit taken;
        pixel <= p;
        pixel_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !pixel_stall;
            @(posedge clk);
        end
        while (!taken);
        stats.absorb_pixel(p);
        pixels_sent++;
    endtask

    task automatic send_image(pps_pkg::pixel_t frame[$]);
        pps_pkg::pixel_t p;
        tx_idle_on = !calm_tail && $urandom_range(0, 2) != 0;
        rx_idle_on = !calm_tail && $urandom_range(0, 2) != 0;
        for (int i = 0; i < frame.size(); i++)
        begin
            p = frame[i];
            p.last_pixel = (i == frame.size() - 1);
            send_pixel(p);
            if (tx_idle_on && $urandom_range(0, 3) == 0)
            begin
                pixel_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        images_sent++;
    endtask

    task automatic send_small_image();
        pps_pkg::pixel_t palette[$];
        pps_pkg::pixel_t frame[$];
        int              len;
        len = $urandom_range(1, 24);
        repeat ($urandom_range(1, 6)) palette.push_back(random_pixel());
        repeat (len)
        begin
            if ($urandom_range(0, 3) == 0)
                frame.push_back(random_pixel());
            else
                frame.push_back(palette[$urandom_range(0, palette.size() - 1)]);
        end
        send_image(frame);
    endtask

    initial
    begin
        pps_pkg::pixel_t frame[$];
        pps_pkg::pixel_t p;
        rst_n <= 1'b0;
        pixel <= '0;
        pixel_valid <= 1'b0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        calm_tail = 1'b0;
        long_hold_req = 1'b0;
        pixels_sent = 0;
        images_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        frame = {make_pixel(16'h0000, 16'h0000, 16'h0000, pps_pkg::CHANNEL_MAX)};
        send_image(frame);
        frame = {make_pixel(16'h1234, 16'h5678, 16'h9ABC, pps_pkg::CHANNEL_ZERO),
                 make_pixel(16'hFFFF, 16'h0000, 16'h0000, pps_pkg::CHANNEL_ZERO),
                 make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, pps_pkg::CHANNEL_MAX)};
        send_image(frame);
        frame = {make_pixel(16'h5555, 16'h5555, 16'h5555, pps_pkg::CHANNEL_MAX),
                 make_pixel(16'h1111, 16'h1111, 16'h1111, pps_pkg::CHANNEL_MAX),
                 make_pixel(16'h1212, 16'h1212, 16'h1212, pps_pkg::CHANNEL_MAX),
                 make_pixel(16'h5555, 16'h1212, 16'h7777, pps_pkg::CHANNEL_MAX),
                 make_pixel(16'h1234, 16'h0000, 16'hFFFF, 16'h8000),
                 make_pixel(16'hAAAA, 16'h7777, 16'h00FF, 16'h0001)};
        send_image(frame);
        frame = {make_pixel(16'h3C3C, 16'h3C3C, 16'h3C3C, 16'h0001),
                 make_pixel(16'h3C3C, 16'h3C3C, 16'h3C3C, 16'hFFFE),
                 make_pixel(16'h3C3C, 16'h3C3C, 16'h3C3C, 16'h0001)};
        send_image(frame);
        frame = {make_pixel(16'h4242, 16'h4242, 16'h4242, pps_pkg::CHANNEL_MAX),
                 make_pixel(16'h4242, 16'h4242, 16'h4243, pps_pkg::CHANNEL_MAX)};
        send_image(frame);

        // hold the output so the queue fills and the input stalls
        long_hold_req = 1'b1;
        repeat (10)
        begin
            frame = {random_pixel()};
            send_image(frame);
        end

        // exactly a full color set, closed by a repeat
        frame = {};
        for (int k = 0; k < SET_SIZE; k++)
        begin
            p = make_pixel({k[7:0], 8'($urandom)}, 16'($urandom), 16'($urandom),
                           pps_pkg::CHANNEL_MAX);
            frame.push_back(p);
        end
        frame.push_back(frame[0]);
        send_image(frame);

        while (pixels_sent < 600)
            send_small_image();

        frame = {};
        repeat (SET_SIZE + 44)
            frame.push_back(make_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom)));
        send_image(frame);

        calm_tail = 1'b1;
        while (pixels_sent < PIXEL_TARGET)
            send_small_image();
        pixel_valid <= 1'b0;

        while (stats.expected_summaries.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d pixels in %0d images; %0d summaries checked, %0d with overflow.",
                 pixels_sent, images_sent, stats.summaries_checked, stats.overflow_summaries);
        $display("Included a full color set, a long output hold and %0d mismatches.",
                 stats.mismatches);
        if (stats.mismatches == 0 && stats.expected_summaries.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ png_pixel_statistics_top.f @@
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/pps_front.sv
rtl/pps_queue.sv
rtl/pps_back.sv
rtl/png_pixel_statistics_top.sv
rtl/pps_checker.sv
sim/png_pixel_statistics_top_test.sv
